>>> design/alts_pkg.sv
// ----------------------------------------------------------------------------
// alts_pkg: shared definitions for the acceleration-limited trajectory step
// Types, codes and widths used by the sequencer and its shared arithmetic unit.
// ----------------------------------------------------------------------------
package alts_pkg;

  // Default parameter values for the top level.
  localparam int FRAC_BITS_DEF  = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed internal widths: operand magnitudes, full products, sums.
  localparam int OPW    = 64;
  localparam int WW     = 128;
  localparam int SUM_W  = OPW + 2;
  localparam int ACC_W  = 31;
  localparam int TIME_W = 17;
  localparam int REM_W  = ACC_W + 1;

  // Iteration counts of the shared unit.
  localparam int MUL_ITER  = OPW;
  localparam int DIV_ITER  = WW;
  localparam int SQRT_ITER = OPW;
  localparam int CNT_W     = $clog2(DIV_ITER);

  // Saturation limit of intermediates, 2^61.
  localparam logic signed [WW-1:0] LIM = 128'sh0000_0000_0000_0000_2000_0000_0000_0000;

  // Operation field codes.
  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_LOAD    = 1'b1;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_TARGET = 2'd2,
    PH_LOADED = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    UOP_MUL  = 2'd0,
    UOP_DIV  = 2'd1,
    UOP_SQRT = 2'd2
  } uop_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_SQRT,
    ST_DIV1,
    ST_DIV2,
    ST_PICK,
    ST_M5,
    ST_M6,
    ST_M7,
    ST_M8,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic start;
    uop_t op;
  } ureq_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ustat_t;

endpackage

>>> design/accel_limited_trajectory_step_core.sv
// ----------------------------------------------------------------------------
// accel_limited_trajectory_step_core: bang-bang trajectory step generator
// Holds a commanded position and velocity and advances them along a
// time-optimal acceleration-limited profile toward a target.
// ----------------------------------------------------------------------------
// Each input item yields one result item. A load item goes from the idle state
// straight to the finish step. An advance item runs on one shared iterative
// unit that produces one bit per cycle, one unit step after another: four
// 64-bit multiplies for the switching sign and the root argument, a 64-step
// square root, two 128-step divides for the switching and final times, and four
// more 64-bit multiplies when the profile is still on an arc. The input is not
// ready while an item is in work; a finished result waits in an output
// register, so the next item may be taken before it is read. Positions and
// velocities are signed fixed point with FRAC_BITS fraction bits; max_accel
// may be written whenever the block is idle.
// ----------------------------------------------------------------------------
module accel_limited_trajectory_step_core #(
  parameter int FRAC_BITS  = alts_pkg::FRAC_BITS_DEF,
  parameter int DATA_WIDTH = alts_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [alts_pkg::ACC_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               operation,
  input  logic [alts_pkg::TIME_W-1:0]        time_step,
  input  logic signed [DATA_WIDTH-1:0]       target_position,
  input  logic signed [DATA_WIDTH-1:0]       target_velocity,
  input  logic signed [DATA_WIDTH-1:0]       load_position,
  input  logic signed [DATA_WIDTH-1:0]       load_velocity,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [DATA_WIDTH-1:0]       position_out,
  output logic signed [DATA_WIDTH-1:0]       velocity_out,
  output logic [1:0]                         phase,
  output logic                               decel_first
);

  localparam int OPW   = alts_pkg::OPW;
  localparam int WW    = alts_pkg::WW;
  localparam int SUM_W = alts_pkg::SUM_W;
  localparam logic signed [SUM_W-1:0] DMAX =
    {{(SUM_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] DMIN = ~DMAX;

  // Saturate a wide signed value to the intermediate limit.
  function automatic logic signed [OPW-1:0] sat_lim(input logic signed [WW-1:0] x);
    logic signed [WW-1:0] y;
    y = x;
    if (x > alts_pkg::LIM) begin
      y = alts_pkg::LIM;
    end else if (x < -alts_pkg::LIM) begin
      y = -alts_pkg::LIM;
    end
    return y[OPW-1:0];
  endfunction

  // Sign extension of a data-width value.
  function automatic logic signed [SUM_W-1:0] ext_d(input logic signed [DATA_WIDTH-1:0] x);
    return {{(SUM_W-DATA_WIDTH){x[DATA_WIDTH-1]}}, x};
  endfunction

  alts_pkg::state_t               state;
  alts_pkg::state_t               state_next;
  alts_pkg::ureq_t                ureq;
  alts_pkg::ustat_t               ust;
  logic [WW-1:0]                  ures;
  logic [WW-1:0]                  u_opa;
  logic [OPW-1:0]                 u_opb;

  logic [alts_pkg::ACC_W-1:0]     max_accel;
  logic signed [DATA_WIDTH-1:0]   pos;
  logic signed [DATA_WIDTH-1:0]   vel;
  logic [alts_pkg::TIME_W-1:0]    t_q;
  logic signed [DATA_WIDTH-1:0]   pf;
  logic signed [DATA_WIDTH-1:0]   vf;
  alts_pkg::phase_t               phase_q;
  alts_pkg::phase_t               phase_o;
  logic                           neg;
  logic signed [WW-1:0]           t1;
  logic signed [WW-1:0]           acc;
  logic [OPW-1:0]                 root;
  logic signed [OPW-1:0]          ts;
  logic signed [OPW-1:0]          tf;
  logic signed [OPW-1:0]          xv;
  logic signed [OPW-1:0]          mq;
  logic signed [OPW-1:0]          xx;
  logic signed [OPW-1:0]          hv;
  logic signed [OPW-1:0]          at;

  logic [alts_pkg::ACC_W-1:0]     au;
  logic signed [SUM_W-1:0]        v66;
  logic signed [SUM_W-1:0]        vf66;
  logic signed [SUM_W-1:0]        dp;
  logic signed [SUM_W-1:0]        dv;
  logic signed [SUM_W-1:0]        sv;
  logic signed [OPW-1:0]          a64;
  logic signed [OPW-1:0]          t64;
  logic signed [OPW-1:0]          sa;
  logic signed [OPW-1:0]          sb;
  logic [OPW-1:0]                 ma;
  logic [OPW-1:0]                 mbv;
  logic                           psign;
  logic signed [WW-1:0]           prod;
  logic signed [OPW-1:0]          mulq_val;
  logic signed [WW-1:0]           s_sum;
  logic signed [WW-1:0]           arg_sum;
  logic signed [SUM_W-1:0]        r66;
  logic signed [SUM_W-1:0]        ndiv;
  logic [SUM_W-1:0]               nmag;
  logic [OPW-1:0]                 qclamp;
  logic signed [OPW-1:0]          div_val;
  logic                           pick_first;
  logic                           pick_second;
  logic                           is_mul;
  logic                           is_unit;
  logic signed [SUM_W-1:0]        p_sum;
  logic signed [SUM_W-1:0]        v_sum;
  logic signed [SUM_W-1:0]        p_sat;
  logic signed [SUM_W-1:0]        v_sat;
  logic                           out_free;

  // Shared arithmetic unit.
  alts_unit u_unit (
    .clk    (clk),
    .rst    (rst),
    .req    (ureq),
    .opa    (u_opa),
    .opb    (u_opb),
    .stat   (ust),
    .result (ures)
  );

  // Differences and sums of the current and target state.
  always_comb begin
    au   = (max_accel == '0) ? alts_pkg::ACC_W'(1) : max_accel;
    v66  = ext_d(vel);
    vf66 = ext_d(vf);
    dp   = ext_d(pf) - v66 + v66 - ext_d(pos);
    dv   = vf66 - v66;
    sv   = vf66 + v66;
    a64  = {{(OPW-alts_pkg::ACC_W){1'b0}}, au};
    t64  = {{(OPW-alts_pkg::TIME_W){1'b0}}, t_q};
  end

  // Multiplier operands for each step.
  always_comb begin
    sa = '0;
    sb = '0;
    case (state)
      alts_pkg::ST_M1: begin
        sa = dp[OPW-1:0];
        sb = {a64[OPW-2:0], 1'b0};
      end
      alts_pkg::ST_M2: begin
        sa = dv[SUM_W-1] ? -dv[OPW-1:0] : dv[OPW-1:0];
        sb = sv[OPW-1:0];
      end
      alts_pkg::ST_M3: begin
        sa = v66[OPW-1:0];
        sb = v66[OPW-1:0];
      end
      alts_pkg::ST_M4: begin
        sa = vf66[OPW-1:0];
        sb = vf66[OPW-1:0];
      end
      alts_pkg::ST_M5: begin
        sa = (phase_q == alts_pkg::PH_FIRST) ? v66[OPW-1:0] : vf66[OPW-1:0];
        sb = xv;
      end
      alts_pkg::ST_M6: begin
        sa = xv;
        sb = xv;
      end
      alts_pkg::ST_M7: begin
        sa = a64;
        sb = xx;
      end
      alts_pkg::ST_M8: begin
        sa = a64;
        sb = xv;
      end
      default: ;
    endcase
    ma       = sa[OPW-1] ? (~sa + 1'b1) : sa;
    mbv      = sb[OPW-1] ? (~sb + 1'b1) : sb;
    psign    = sa[OPW-1] ^ sb[OPW-1];
    prod     = psign ? -$signed(ures) : $signed(ures);
    mulq_val = sat_lim(prod >>> FRAC_BITS);
    s_sum    = t1 + prod;
    arg_sum  = acc + prod + (neg ? -t1 : t1);
  end

  // Divider numerator and quotient clamp.
  always_comb begin
    r66 = {{(SUM_W-OPW){1'b0}}, root};
    if (state == alts_pkg::ST_DIV1) begin
      ndiv = neg ? (v66 + r66) : (r66 - v66);
    end else begin
      ndiv = neg ? (v66 + vf66 + (r66 <<< 1)) : ((r66 <<< 1) - v66 - vf66);
    end
    nmag    = ndiv[SUM_W-1] ? (~ndiv + 1'b1) : ndiv;
    qclamp  = ($signed(ures) > alts_pkg::LIM) ? alts_pkg::LIM[OPW-1:0] : ures[OPW-1:0];
    div_val = ndiv[SUM_W-1] ? -$signed(qclamp) : $signed(qclamp);
  end

  // Profile selection at the time step.
  assign pick_first  = (t64 < ts);
  assign pick_second = (t64 < tf);

  // Final position and velocity, saturated to the data width.
  always_comb begin
    if (phase_q == alts_pkg::PH_FIRST || phase_q == alts_pkg::PH_SECOND) begin
      p_sum = ((phase_q == alts_pkg::PH_FIRST) ? ext_d(pos) : ext_d(pf)) +
              ((phase_q == alts_pkg::PH_SECOND) ? -SUM_W'(mq) : SUM_W'(mq)) +
              ((neg ^ (phase_q == alts_pkg::PH_SECOND)) ? -SUM_W'(hv) : SUM_W'(hv));
      v_sum = ((phase_q == alts_pkg::PH_FIRST) ? v66 : vf66) +
              (neg ? -SUM_W'(at) : SUM_W'(at));
    end else begin
      p_sum = ext_d(pf);
      v_sum = vf66;
    end
    p_sat = (p_sum > DMAX) ? DMAX : ((p_sum < DMIN) ? DMIN : p_sum);
    v_sat = (v_sum > DMAX) ? DMAX : ((v_sum < DMIN) ? DMIN : v_sum);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      alts_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (operation == alts_pkg::OP_LOAD) ? alts_pkg::ST_FIN : alts_pkg::ST_M1;
        end
      end
      alts_pkg::ST_M1:   if (ust.done) state_next = alts_pkg::ST_M2;
      alts_pkg::ST_M2:   if (ust.done) state_next = alts_pkg::ST_M3;
      alts_pkg::ST_M3:   if (ust.done) state_next = alts_pkg::ST_M4;
      alts_pkg::ST_M4:   if (ust.done) state_next = alts_pkg::ST_SQRT;
      alts_pkg::ST_SQRT: if (ust.done) state_next = alts_pkg::ST_DIV1;
      alts_pkg::ST_DIV1: if (ust.done) state_next = alts_pkg::ST_DIV2;
      alts_pkg::ST_DIV2: if (ust.done) state_next = alts_pkg::ST_PICK;
      alts_pkg::ST_PICK: begin
        state_next = (pick_first || pick_second) ? alts_pkg::ST_M5 : alts_pkg::ST_FIN;
      end
      alts_pkg::ST_M5:   if (ust.done) state_next = alts_pkg::ST_M6;
      alts_pkg::ST_M6:   if (ust.done) state_next = alts_pkg::ST_M7;
      alts_pkg::ST_M7:   if (ust.done) state_next = alts_pkg::ST_M8;
      alts_pkg::ST_M8:   if (ust.done) state_next = alts_pkg::ST_FIN;
      alts_pkg::ST_FIN:  if (out_free) state_next = alts_pkg::ST_IDLE;
      default:           state_next = alts_pkg::ST_IDLE;
    endcase
  end

  // Handshake and unit requests.
  always_comb begin
    is_mul = 1'b0;
    case (state)
      alts_pkg::ST_M1, alts_pkg::ST_M2, alts_pkg::ST_M3, alts_pkg::ST_M4,
      alts_pkg::ST_M5, alts_pkg::ST_M6, alts_pkg::ST_M7, alts_pkg::ST_M8: is_mul = 1'b1;
      default: is_mul = 1'b0;
    endcase
    is_unit    = is_mul || (state == alts_pkg::ST_SQRT) ||
                 (state == alts_pkg::ST_DIV1) || (state == alts_pkg::ST_DIV2);
    ureq.start = is_unit && !ust.busy && !ust.done;
    if (state == alts_pkg::ST_SQRT) begin
      ureq.op = alts_pkg::UOP_SQRT;
      u_opa   = acc[WW-1] ? '0 : ($unsigned(acc) >> 1);
      u_opb   = '0;
    end else if (state == alts_pkg::ST_DIV1 || state == alts_pkg::ST_DIV2) begin
      ureq.op = alts_pkg::UOP_DIV;
      u_opa   = WW'(nmag) << FRAC_BITS;
      u_opb   = {{(OPW-alts_pkg::ACC_W){1'b0}}, au};
    end else begin
      ureq.op = alts_pkg::UOP_MUL;
      u_opa   = {{(WW-OPW){1'b0}}, ma};
      u_opb   = mbv;
    end
    in_ready  = (state == alts_pkg::ST_IDLE);
    cfg_ready = 1'b1;
    out_free  = !out_valid || out_ready;
  end

  // Control state, stored position and velocity, output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= alts_pkg::ST_IDLE;
      out_valid <= 1'b0;
      pos       <= '0;
      vel       <= '0;
      max_accel <= alts_pkg::ACC_W'(1) << FRAC_BITS;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        max_accel <= cfg_data;
      end
      if (state == alts_pkg::ST_FIN && out_free) begin
        out_valid <= 1'b1;
        pos       <= p_sat[DATA_WIDTH-1:0];
        vel       <= v_sat[DATA_WIDTH-1:0];
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk) begin
    if (state == alts_pkg::ST_IDLE && in_valid) begin
      t_q <= time_step;
      if (operation == alts_pkg::OP_LOAD) begin
        pf      <= load_position;
        vf      <= load_velocity;
        phase_q <= alts_pkg::PH_LOADED;
        neg     <= 1'b0;
      end else begin
        pf <= target_position;
        vf <= target_velocity;
      end
    end
    if (ust.done) begin
      case (state)
        alts_pkg::ST_M1:   t1 <= prod;
        alts_pkg::ST_M2: begin
          neg <= s_sum[WW-1];
        end
        alts_pkg::ST_M3:   acc <= prod;
        alts_pkg::ST_M4:   acc <= arg_sum;
        alts_pkg::ST_SQRT: root <= ures[OPW-1:0];
        alts_pkg::ST_DIV1: ts <= div_val;
        alts_pkg::ST_DIV2: tf <= div_val;
        alts_pkg::ST_M5:   mq <= mulq_val;
        alts_pkg::ST_M6:   xx <= mulq_val;
        alts_pkg::ST_M7:   hv <= mulq_val >>> 1;
        alts_pkg::ST_M8:   at <= mulq_val;
        default: ;
      endcase
    end
    if (state == alts_pkg::ST_PICK) begin
      if (pick_first) begin
        phase_q <= alts_pkg::PH_FIRST;
        xv      <= t64;
      end else if (pick_second) begin
        phase_q <= alts_pkg::PH_SECOND;
        xv      <= tf - t64;
      end else begin
        phase_q <= alts_pkg::PH_TARGET;
      end
    end
    if (state == alts_pkg::ST_FIN && out_free) begin
      position_out <= p_sat[DATA_WIDTH-1:0];
      velocity_out <= v_sat[DATA_WIDTH-1:0];
      phase_o      <= phase_q;
      decel_first  <= neg;
    end
  end

  assign phase = phase_o;

`ifndef SYNTHESIS
  a_ready_unit_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !ust.busy)
    else $error("input ready while the shared unit is busy");
  a_load_to_fin: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && operation == alts_pkg::OP_LOAD) |=> (state == alts_pkg::ST_FIN))
    else $error("load item did not go straight to the finish step");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    ust.done |-> $past(ust.busy))
    else $error("unit done without a preceding busy cycle");
  a_loaded_no_decel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && phase == alts_pkg::PH_LOADED) |-> !decel_first)
    else $error("loaded result flags decelerate first");
`endif

endmodule

>>> design/alts_unit.sv
// ----------------------------------------------------------------------------
// alts_unit: shared iterative arithmetic unit
// One wide adder serves a shift-add multiplier, a restoring divider and a
// digit-by-digit square root, one bit of result per cycle.
// ----------------------------------------------------------------------------
module alts_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  alts_pkg::ureq_t           req,
  input  logic [alts_pkg::WW-1:0]   opa,
  input  logic [alts_pkg::OPW-1:0]  opb,
  output alts_pkg::ustat_t          stat,
  output logic [alts_pkg::WW-1:0]   result
);

  logic                           busy;
  logic                           done;
  logic [alts_pkg::CNT_W-1:0]     cnt;
  alts_pkg::uop_t                 op_q;
  logic [alts_pkg::WW-1:0]        acc;
  logic [alts_pkg::WW-1:0]        sh;
  logic [alts_pkg::OPW-1:0]       mb;
  logic [alts_pkg::WW-1:0]        add_a;
  logic [alts_pkg::WW-1:0]        add_b;
  logic                           sub;
  logic [alts_pkg::WW:0]          sum;
  logic                           carry;

  // Operand selection for the shared adder.
  always_comb begin
    add_a = '0;
    add_b = '0;
    sub   = 1'b0;
    case (op_q)
      alts_pkg::UOP_MUL: begin
        add_a = acc;
        add_b = sh;
      end
      alts_pkg::UOP_DIV: begin
        add_a = {{(alts_pkg::WW-alts_pkg::REM_W-1){1'b0}},
                 acc[alts_pkg::REM_W-1:0], sh[alts_pkg::WW-1]};
        add_b = {{(alts_pkg::WW-alts_pkg::OPW){1'b0}}, mb};
        sub   = 1'b1;
      end
      alts_pkg::UOP_SQRT: begin
        add_a = {acc[alts_pkg::WW-3:0], sh[alts_pkg::WW-1:alts_pkg::WW-2]};
        add_b = {{(alts_pkg::WW-alts_pkg::OPW-2){1'b0}}, mb, 2'b01};
        sub   = 1'b1;
      end
      default: ;
    endcase
    sum   = {1'b0, add_a} + {1'b0, (sub ? ~add_b : add_b)} +
            {{alts_pkg::WW{1'b0}}, sub};
    carry = sum[alts_pkg::WW];
  end

  // Sequencing of the iterations.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op_q <= alts_pkg::UOP_MUL;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        op_q <= req.op;
        case (req.op)
          alts_pkg::UOP_DIV:  cnt <= alts_pkg::CNT_W'(alts_pkg::DIV_ITER - 1);
          alts_pkg::UOP_SQRT: cnt <= alts_pkg::CNT_W'(alts_pkg::SQRT_ITER - 1);
          default:            cnt <= alts_pkg::CNT_W'(alts_pkg::MUL_ITER - 1);
        endcase
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers: one result bit per cycle.
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      acc <= '0;
      sh  <= opa;
      mb  <= (req.op == alts_pkg::UOP_SQRT) ? '0 : opb;
    end else if (busy) begin
      case (op_q)
        alts_pkg::UOP_MUL: begin
          if (mb[0]) begin
            acc <= sum[alts_pkg::WW-1:0];
          end
          sh <= {sh[alts_pkg::WW-2:0], 1'b0};
          mb <= {1'b0, mb[alts_pkg::OPW-1:1]};
        end
        alts_pkg::UOP_DIV: begin
          acc <= carry ? sum[alts_pkg::WW-1:0] : add_a;
          sh  <= {sh[alts_pkg::WW-2:0], carry};
        end
        alts_pkg::UOP_SQRT: begin
          acc <= carry ? sum[alts_pkg::WW-1:0] : add_a;
          sh  <= {sh[alts_pkg::WW-3:0], 2'b00};
          mb  <= {mb[alts_pkg::OPW-2:0], carry};
        end
        default: ;
      endcase
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

  // Product, quotient or root, held until the next start.
  always_comb begin
    case (op_q)
      alts_pkg::UOP_DIV:  result = sh;
      alts_pkg::UOP_SQRT: result = {{(alts_pkg::WW-alts_pkg::OPW){1'b0}}, mb};
      default:            result = acc;
    endcase
  end

endmodule
